>>> rtl/reme_pkg.sv
// Shared types, codes and reset values for the rotary encoder menu input block.
package reme_pkg;

    // Event kinds carried in the op field
    typedef enum logic {
        OP_ENCODER = 1'b0,
        OP_BUTTON  = 1'b1
    } reme_op_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_ENC_LOCKOUT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BTN_LOCKOUT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MENU_ENTRIES = 2'd2;

    // Register reset values
    localparam logic [15:0] RESET_ENC_LOCKOUT  = 16'd50;
    localparam logic [15:0] RESET_BTN_LOCKOUT  = 16'd500;
    localparam logic [4:0]  RESET_MENU_ENTRIES = 5'd3;
    localparam logic [4:0]  MAX_MENU_ENTRIES   = 5'd16;

    // Input item
    typedef struct packed {
        reme_op_t    op;
        logic [31:0] time_ms;
        logic        pin_a;
        logic        pin_b;
    } reme_in_t;

    // Result item
    typedef struct packed {
        logic               event_accepted;
        logic               set_mode;
        logic [3:0]         menu_index;
        logic signed [15:0] value_count;
        logic signed [15:0] encoder_count;
        logic               value_confirmed;
    } reme_out_t;

    // Live configuration handed to the update logic
    typedef struct packed {
        logic [15:0] enc_lockout;
        logic [15:0] btn_lockout;
        logic [4:0]  menu_entries;
    } reme_cfg_t;

endpackage

>>> rtl/reme_cfg.sv
// Configuration registers: lockout times and menu size.
module reme_cfg
    import reme_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output reme_cfg_t              cfg
);

    reme_cfg_t cfg_reg;
    reme_cfg_t cfg_next;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ENC_LOCKOUT:  cfg_next.enc_lockout  = cfg_wdata;
                REG_BTN_LOCKOUT:  cfg_next.btn_lockout  = cfg_wdata;
                REG_MENU_ENTRIES: cfg_next.menu_entries = cfg_wdata[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enc_lockout  <= RESET_ENC_LOCKOUT;
            cfg_reg.btn_lockout  <= RESET_BTN_LOCKOUT;
            cfg_reg.menu_entries <= RESET_MENU_ENTRIES;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/reme_in_reg.sv
// Input register: holds one accepted item until the update logic takes it.
module reme_in_reg
    import reme_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  reme_in_t s_item,
    input  logic     advance,
    output logic     in_valid,
    output reme_in_t in_item
);

    logic     valid_reg;
    reme_in_t item_reg;

    // Take a new item when empty or when the held one moves on
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

>>> rtl/reme_core.sv
// Event state and combinational update: lockout checks, counters, menu and mode.
module reme_core
    import reme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  reme_cfg_t cfg,
    input  logic      advance,
    input  reme_in_t  in_item,
    output reme_out_t result
);

    logic [31:0] last_edge_time_reg,  last_edge_time_next;
    logic [31:0] last_press_time_reg, last_press_time_next;
    logic [15:0] position_count_reg,  position_count_next;
    logic        mode_flag_reg,       mode_flag_next;
    logic [3:0]  menu_pointer_reg,    menu_pointer_next;
    logic [15:0] adjust_count_reg,    adjust_count_next;

    logic [31:0] edge_elapsed;
    logic [31:0] press_elapsed;
    logic        edge_ok;
    logic        press_ok;
    logic        step_up;
    logic [4:0]  entries;
    logic [4:0]  ptr_ext;
    logic [4:0]  ptr_step;
    logic        accepted;
    logic        confirmed;

    // Elapsed times wrap modulo 2^32
    assign edge_elapsed  = in_item.time_ms - last_edge_time_reg;
    assign press_elapsed = in_item.time_ms - last_press_time_reg;
    assign edge_ok       = edge_elapsed  > {16'd0, cfg.enc_lockout};
    assign press_ok      = press_elapsed > {16'd0, cfg.btn_lockout};
    assign step_up       = (in_item.pin_a == in_item.pin_b);

    // Clamp menu size to 1..16
    always_comb begin
        if (cfg.menu_entries == 5'd0) begin
            entries = 5'd1;
        end else if (cfg.menu_entries > MAX_MENU_ENTRIES) begin
            entries = MAX_MENU_ENTRIES;
        end else begin
            entries = cfg.menu_entries;
        end
    end

    // Wrap the menu pointer; a stale pointer jumps to an end of the menu
    assign ptr_ext = {1'b0, menu_pointer_reg};
    always_comb begin
        if (step_up) begin
            ptr_step = (ptr_ext + 5'd1 >= entries) ? 5'd0 : ptr_ext + 5'd1;
        end else begin
            ptr_step = (ptr_ext == 5'd0 || ptr_ext >= entries) ? entries - 5'd1
                                                               : ptr_ext - 5'd1;
        end
    end

    // Next state for the item at the input register
    always_comb begin
        last_edge_time_next  = last_edge_time_reg;
        last_press_time_next = last_press_time_reg;
        position_count_next  = position_count_reg;
        mode_flag_next       = mode_flag_reg;
        menu_pointer_next    = menu_pointer_reg;
        adjust_count_next    = adjust_count_reg;
        accepted             = 1'b0;
        confirmed            = 1'b0;
        case (in_item.op)
            OP_ENCODER: begin
                if (edge_ok) begin
                    accepted            = 1'b1;
                    last_edge_time_next = in_item.time_ms;
                    position_count_next = step_up ? position_count_reg + 16'd1
                                                  : position_count_reg - 16'd1;
                    if (!mode_flag_reg) begin
                        menu_pointer_next = ptr_step[3:0];
                    end else begin
                        adjust_count_next = step_up ? adjust_count_reg + 16'd1
                                                    : adjust_count_reg - 16'd1;
                    end
                end
            end
            OP_BUTTON: begin
                // Every press records its time
                last_press_time_next = in_item.time_ms;
                if (press_ok) begin
                    accepted       = 1'b1;
                    mode_flag_next = !mode_flag_reg;
                    confirmed      = mode_flag_reg;
                end
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    // Commit when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_time_reg  <= 32'd0;
            last_press_time_reg <= 32'd0;
            position_count_reg  <= 16'd0;
            mode_flag_reg       <= 1'b0;
            menu_pointer_reg    <= 4'd0;
            adjust_count_reg    <= 16'd0;
        end else if (advance) begin
            last_edge_time_reg  <= last_edge_time_next;
            last_press_time_reg <= last_press_time_next;
            position_count_reg  <= position_count_next;
            mode_flag_reg       <= mode_flag_next;
            menu_pointer_reg    <= menu_pointer_next;
            adjust_count_reg    <= adjust_count_next;
        end
    end

    // Result reflects state after the update
    always_comb begin
        result.event_accepted  = accepted;
        result.set_mode        = mode_flag_next;
        result.menu_index      = menu_pointer_next;
        result.value_count     = adjust_count_next;
        result.encoder_count   = position_count_next;
        result.value_confirmed = confirmed;
    end

endmodule

>>> rtl/reme_out_reg.sv
// Result register: holds one finished item until the consumer takes it.
module reme_out_reg
    import reme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  reme_out_t result,
    output logic      m_valid,
    input  logic      m_ready,
    output reme_out_t m_item
);

    logic      valid_reg;
    reme_out_t item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

>>> rtl/rotary_encoder_menu_input.sv
// Top level of the rotary encoder and push-button menu input block.
//
//   Port group       Dir   Handshake         Carries
//   s_*              in    s_valid/s_ready   encoder edge or button press item
//   m_*              out   m_valid/m_ready   one result item per input item
//   cfg_*            in    cfg_we            lockout times and menu size
//
// An item waits in the input register, is updated in one pass and lands in
// the result register when it moves on. Throughput is one item per cycle
// while m_ready stays high.
// A stalled result holds the result register and then the input register;
// s_ready drops only when both are full.
// aresetn (synchronous, active low) clears control state and loads reset values.
module rotary_encoder_menu_input
    import reme_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  reme_in_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output reme_out_t              m_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    reme_cfg_t cfg;
    reme_in_t  in_item;
    reme_out_t result;
    logic      in_valid;
    logic      advance;

    // Move the held item on when the result register is free
    assign advance = in_valid && (!m_valid || m_ready);

    reme_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    reme_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    reme_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .in_item (in_item),
        .result  (result)
    );

    reme_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .result  (result),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef SYNTHESIS
    // A confirm only comes from an accepted press that returns to select mode
    a_confirm_leaves_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.value_confirmed |-> m_item.event_accepted && !m_item.set_mode)
        else $error("confirm without accepted return to select mode");

    // An item that moves on shows up as a result next cycle
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item did not reach the result register");

    // An empty input register never back-pressures
    a_empty_is_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |-> s_ready)
        else $error("input register empty but not ready");
`endif

endmodule
